// ===== rtl/core/tks3_pkg.sv =====
// shared types and constants of the three-set top sums unit
// no dependencies

package tks3_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PAIR_W = 33;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned REG_W  = 7;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_C = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_COUNT_A = 2'd0,
    REG_COUNT_B = 2'd1,
    REG_COUNT_C = 2'd2,
    REG_TOP_K   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_SEND
  } state_e;

endpackage

// ===== rtl/core/top_k_sums_of_three_sets_unit.sv =====
// top level of the three-set top sums unit: set memories, pair memory, scan control
// depends on tks3_pkg
//
// usage: load items (operation 0..2) write one element of set a, b or c at slot;
// a load gives no result. a run item (operation 3) emits the top_k largest sums
// a+b+c with multiplicity, in non-increasing order, each with its rank; the final
// result carries last.
// configuration (count_a, count_b, count_c, top_k) is written on the cfg channel,
// always ready; the user must write it only while the unit is idle, as the block does not enforce this.
// a run first builds the top_k largest b+c sums in the pair memory, then the
// result list from a and the pair memory. each distinct sum value costs one scan
// over all count_b*count_c (resp. count_a*pairs) index pairs, through the single
// read port of each set memory; repeats of that value then need no new scan.
// the input is not ready until the run has delivered its last result. a stalled
// receiver holds the current result and the scan waits.
// reset sets all counts to 1 and returns to idle; set memories are not cleared.

module top_k_sums_of_three_sets_unit #(
  parameter int unsigned SET_DEPTH  = 64,
  parameter int unsigned MAX_K      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tks3_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [tks3_pkg::REG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [tks3_pkg::SLOT_W-1:0]   slot_i,
  input  logic [tks3_pkg::VAL_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tks3_pkg::SUM_W-1:0]    sum_o,
  output logic [tks3_pkg::RANK_W-1:0]   rank_o,
  output logic                          last_o
);

  localparam int unsigned AW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(SET_DEPTH + 1);
  localparam int unsigned KW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KCW  = $clog2(MAX_K + 1);
  localparam int unsigned JW   = (AW > KW) ? AW : KW;
  localparam int unsigned NJW  = (CW > KCW) ? CW : KCW;
  localparam int unsigned TW   = $clog2(SET_DEPTH * SET_DEPTH + SET_DEPTH * MAX_K + 1);
  localparam int unsigned PW   = CW + KCW;
  localparam logic [tks3_pkg::VAL_W-1:0] ValMask = (VALUE_BITS >= 32) ? '1 :
      tks3_pkg::VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  // configuration registers
  logic [tks3_pkg::REG_W-1:0] cnt_a_q, cnt_b_q, cnt_c_q, top_k_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= tks3_pkg::REG_W'(1);
      cnt_b_q <= tks3_pkg::REG_W'(1);
      cnt_c_q <= tks3_pkg::REG_W'(1);
      top_k_q <= tks3_pkg::REG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (tks3_pkg::reg_e'(cfg_index_i))
        tks3_pkg::REG_COUNT_A: cnt_a_q <= cfg_data_i;
        tks3_pkg::REG_COUNT_B: cnt_b_q <= cfg_data_i;
        tks3_pkg::REG_COUNT_C: cnt_c_q <= cfg_data_i;
        tks3_pkg::REG_TOP_K:   top_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated counts
  logic [CW-1:0]  na, nb, nc;
  logic [KCW-1:0] kk;

  assign na = ({25'd0, cnt_a_q} > 32'(SET_DEPTH)) ? CW'(SET_DEPTH) : CW'(cnt_a_q);
  assign nb = ({25'd0, cnt_b_q} > 32'(SET_DEPTH)) ? CW'(SET_DEPTH) : CW'(cnt_b_q);
  assign nc = ({25'd0, cnt_c_q} > 32'(SET_DEPTH)) ? CW'(SET_DEPTH) : CW'(cnt_c_q);
  assign kk = ({25'd0, top_k_q} > 32'(MAX_K)) ? KCW'(MAX_K) : KCW'(top_k_q);

  // control state
  tks3_pkg::state_e state_q, state_d;
  logic              stage2_q, stage2_d;
  logic [AW-1:0]     i_q, i_d;
  logic [JW-1:0]     j_q, j_d;
  logic              idone_q, idone_d;
  logic              vld_q, vld_d;
  logic              found_q, found_d;
  logic [tks3_pkg::SUM_W-1:0] best_q, best_d;
  logic [tks3_pkg::SUM_W-1:0] thr_q, thr_d;
  logic              has_thr_q, has_thr_d;
  logic [TW-1:0]     tie_q, tie_d;
  logic [KCW-1:0]    pc_q, pc_d;
  logic [KCW-1:0]    np_q, np_d;
  logic [KCW-1:0]    ne_q, ne_d;
  logic [KCW-1:0]    lim_q, lim_d;

  // memories and registered read data
  logic [tks3_pkg::VAL_W-1:0]  mem_a [SET_DEPTH];
  logic [tks3_pkg::VAL_W-1:0]  mem_b [SET_DEPTH];
  logic [tks3_pkg::VAL_W-1:0]  mem_c [SET_DEPTH];
  logic [tks3_pkg::PAIR_W-1:0] mem_p [MAX_K];
  logic [tks3_pkg::VAL_W-1:0]  rd_a_q, rd_b_q, rd_c_q;
  logic [tks3_pkg::PAIR_W-1:0] rd_p_q;

  logic in_acc, slot_ok;
  assign in_acc  = in_valid_i && in_ready_o;
  assign slot_ok = {26'd0, slot_i} < 32'(SET_DEPTH);

  always_ff @(posedge clk_i) begin
    if (in_acc && slot_ok) begin
      case (tks3_pkg::op_e'(operation_i))
        tks3_pkg::OP_LOAD_A: mem_a[AW'(slot_i)] <= value_i & ValMask;
        tks3_pkg::OP_LOAD_B: mem_b[AW'(slot_i)] <= value_i & ValMask;
        tks3_pkg::OP_LOAD_C: mem_c[AW'(slot_i)] <= value_i & ValMask;
        default: ;
      endcase
    end
    if (state_q == tks3_pkg::ST_FILL) begin
      mem_p[pc_q[KW-1:0]] <= best_q[tks3_pkg::PAIR_W-1:0];
    end
    rd_a_q <= mem_a[i_q];
    rd_b_q <= mem_b[i_q];
    rd_c_q <= mem_c[j_q[AW-1:0]];
    rd_p_q <= mem_p[j_q[KW-1:0]];
  end

  // scan operands and sum
  logic [CW-1:0]  ni;
  logic [NJW-1:0] nj;
  logic [tks3_pkg::VAL_W-1:0]  op_x;
  logic [tks3_pkg::PAIR_W-1:0] op_y;
  logic [tks3_pkg::SUM_W-1:0]  s;

  assign ni   = stage2_q ? na : nb;
  assign nj   = stage2_q ? NJW'(np_q) : NJW'(nc);
  assign op_x = stage2_q ? rd_a_q : rd_b_q;
  assign op_y = stage2_q ? rd_p_q : {1'b0, rd_c_q};
  assign s    = {2'b00, op_x} + {1'b0, op_y};

  // pair count and result limit at the switch to the second stage
  logic [KCW-1:0] np_new;
  logic [PW-1:0]  prod;
  logic [KCW-1:0] lim_new;

  assign np_new  = (state_q == tks3_pkg::ST_FILL) ? pc_q + KCW'(1) : pc_q;
  assign prod    = PW'(na) * PW'(np_new);
  assign lim_new = (prod > PW'(kk)) ? kk : KCW'(prod);

  // outputs
  assign in_ready_o  = (state_q == tks3_pkg::ST_IDLE);
  assign out_valid_o = (state_q == tks3_pkg::ST_SEND);
  assign sum_o       = best_q;
  assign rank_o      = tks3_pkg::RANK_W'(ne_q);
  assign last_o      = (ne_q + KCW'(1) == lim_q);

  // next state and scan control
  always_comb begin
    state_d   = state_q;
    stage2_d  = stage2_q;
    i_d       = i_q;
    j_d       = j_q;
    idone_d   = idone_q;
    vld_d     = 1'b0;
    found_d   = found_q;
    best_d    = best_q;
    thr_d     = thr_q;
    has_thr_d = has_thr_q;
    tie_d     = tie_q;
    pc_d      = pc_q;
    np_d      = np_q;
    ne_d      = ne_q;
    lim_d     = lim_q;
    unique case (state_q)
      tks3_pkg::ST_IDLE: begin
        if (in_acc && (tks3_pkg::op_e'(operation_i) == tks3_pkg::OP_RUN) &&
            (na != '0) && (nb != '0) && (nc != '0) && (kk != '0)) begin
          stage2_d  = 1'b0;
          pc_d      = '0;
          has_thr_d = 1'b0;
          i_d       = '0;
          j_d       = '0;
          idone_d   = 1'b0;
          found_d   = 1'b0;
          state_d   = tks3_pkg::ST_SCAN;
        end
      end
      tks3_pkg::ST_SCAN: begin
        // issue reads over all index pairs
        if (!idone_q) begin
          vld_d = 1'b1;
          if (j_q == JW'(nj - NJW'(1))) begin
            j_d = '0;
            if (i_q == AW'(ni - CW'(1))) idone_d = 1'b1;
            else i_d = i_q + AW'(1);
          end else begin
            j_d = j_q + JW'(1);
          end
        end
        // largest sum below the threshold and its multiplicity
        if (vld_q && (!has_thr_q || (s < thr_q))) begin
          if (!found_q || (s > best_q)) begin
            found_d = 1'b1;
            best_d  = s;
            tie_d   = TW'(1);
          end else if (s == best_q) begin
            tie_d = tie_q + TW'(1);
          end
        end
        // scan complete
        if (idone_q && !vld_q) begin
          if (found_q) begin
            thr_d     = best_q;
            has_thr_d = 1'b1;
            state_d   = stage2_q ? tks3_pkg::ST_SEND : tks3_pkg::ST_FILL;
          end else if (!stage2_q) begin
            np_d      = np_new;
            lim_d     = lim_new;
            ne_d      = '0;
            stage2_d  = 1'b1;
            has_thr_d = 1'b0;
            i_d       = '0;
            j_d       = '0;
            idone_d   = 1'b0;
            found_d   = 1'b0;
          end else begin
            state_d = tks3_pkg::ST_IDLE;
          end
        end
      end
      tks3_pkg::ST_FILL: begin
        pc_d  = pc_q + KCW'(1);
        tie_d = tie_q - TW'(1);
        if (np_new == kk) begin
          np_d      = np_new;
          lim_d     = lim_new;
          ne_d      = '0;
          stage2_d  = 1'b1;
          has_thr_d = 1'b0;
          i_d       = '0;
          j_d       = '0;
          idone_d   = 1'b0;
          found_d   = 1'b0;
          state_d   = tks3_pkg::ST_SCAN;
        end else if (tie_q == TW'(1)) begin
          i_d     = '0;
          j_d     = '0;
          idone_d = 1'b0;
          found_d = 1'b0;
          state_d = tks3_pkg::ST_SCAN;
        end
      end
      tks3_pkg::ST_SEND: begin
        if (out_ready_i) begin
          ne_d  = ne_q + KCW'(1);
          tie_d = tie_q - TW'(1);
          if (last_o) begin
            state_d = tks3_pkg::ST_IDLE;
          end else if (tie_q == TW'(1)) begin
            i_d     = '0;
            j_d     = '0;
            idone_d = 1'b0;
            found_d = 1'b0;
            state_d = tks3_pkg::ST_SCAN;
          end
        end
      end
      default: state_d = tks3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tks3_pkg::ST_IDLE;
      stage2_q  <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      idone_q   <= 1'b0;
      vld_q     <= 1'b0;
      found_q   <= 1'b0;
      has_thr_q <= 1'b0;
      tie_q     <= '0;
      pc_q      <= '0;
      np_q      <= '0;
      ne_q      <= '0;
      lim_q     <= '0;
    end else begin
      state_q   <= state_d;
      stage2_q  <= stage2_d;
      i_q       <= i_d;
      j_q       <= j_d;
      idone_q   <= idone_d;
      vld_q     <= vld_d;
      found_q   <= found_d;
      has_thr_q <= has_thr_d;
      tie_q     <= tie_d;
      pc_q      <= pc_d;
      np_q      <= np_d;
      ne_q      <= ne_d;
      lim_q     <= lim_d;
    end
  end

  // sum payload registers
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    thr_q  <= thr_d;
  end

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input ready while a result is shown");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("run did not end after its last item");

  a_run_goes_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (state_q == tks3_pkg::ST_SEND || state_q == tks3_pkg::ST_SCAN))
    else $error("run stopped before its last item");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == tks3_pkg::ST_SCAN)) else $error("read data outside a scan");

  a_tie_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tks3_pkg::ST_FILL || state_q == tks3_pkg::ST_SEND) |-> (tie_q != '0))
    else $error("emitting a sum value with no copies left");

endmodule
